@@ design/stla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Session table package
// Types, codes and constants shared by the session table cells, channel
// interfaces and top level.
// ----------------------------------------------------------------------------
package stla_pkg;

  localparam int DEF_MAX_SESSIONS = 16;

  localparam int KEY_W    = 48;
  localparam int LEN_W    = 4;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_AGE    = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_HIT   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NEW   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_SWEEP = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic hit;
    logic free_found;
  } flags_t;

endpackage
`default_nettype wire

@@ design/stla_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Session table channel interfaces
// Valid/ready channels for the input word and the result word.
// ----------------------------------------------------------------------------
interface stla_in_if
  import stla_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              op;
  logic [KEY_W-1:0]  addr_key;
  logic [LEN_W-1:0]  addr_len;
  logic [TIME_W-1:0] now_ticks;

  modport source (output valid, output op, output addr_key, output addr_len,
                  output now_ticks, input ready);
  modport sink (input valid, input op, input addr_key, input addr_len,
                input now_ticks, output ready);
endinterface

interface stla_out_if
  import stla_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  live_count;
  logic [COUNT_W-1:0]  evicted;

  modport source (output valid, output status, output slot, output live_count,
                  output evicted, input ready);
  modport sink (input valid, input status, input slot, input live_count,
                input evicted, output ready);
endinterface
`default_nettype wire

@@ design/stla_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Session table cell
// Holds one table entry and processes the word token passing through it,
// then hands the token to the next cell.
// ----------------------------------------------------------------------------
module stla_cell
  import stla_pkg::*;
#(
  parameter int IDX_W        = 4,
  parameter int CNT_W        = 5,
  parameter int CELL_IDX     = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [TIME_W-1:0] timeout,
  input  wire logic              tok_vld_i,
  input  wire item_t             item_i,
  input  wire flags_t            flags_i,
  input  wire logic [IDX_W-1:0]  hit_slot_i,
  input  wire logic [IDX_W-1:0]  free_slot_i,
  input  wire logic [CNT_W-1:0]  evict_i,
  output logic                   tok_vld_o,
  output item_t                  item_o,
  output flags_t                 flags_o,
  output logic [IDX_W-1:0]       hit_slot_o,
  output logic [IDX_W-1:0]       free_slot_o,
  output logic [CNT_W-1:0]       evict_o,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_slot,
  input  wire item_t             wr_item,
  output logic                   valid_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic              valid_r, valid_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;

  logic              tok_vld_r;
  item_t             item_r;
  flags_t            flags_r, flags_nxt;
  logic [IDX_W-1:0]  hit_slot_r, hit_slot_nxt;
  logic [IDX_W-1:0]  free_slot_r, free_slot_nxt;
  logic [CNT_W-1:0]  evict_r, evict_nxt;

  logic              match;
  logic [TIME_W-1:0] age;
  logic              expire;

  assign match  = valid_r && (key_r == item_i.key) && (len_r == item_i.len);
  assign age    = item_i.now - last_r;
  assign expire = valid_r && (age >= timeout);

  always_comb begin
    valid_nxt     = valid_r;
    key_nxt       = key_r;
    len_nxt       = len_r;
    last_nxt      = last_r;
    flags_nxt     = flags_i;
    hit_slot_nxt  = hit_slot_i;
    free_slot_nxt = free_slot_i;
    evict_nxt     = evict_i;
    if (tok_vld_i) begin
      if (item_i.op == OP_AGE) begin
        if (expire) begin
          valid_nxt = 1'b0;
          evict_nxt = evict_i + CNT_W'(1);
        end
      end else if (!flags_i.hit && match) begin
        flags_nxt.hit = 1'b1;
        hit_slot_nxt  = MY_IDX;
        last_nxt      = item_i.now;
      end else if (!flags_i.free_found && !valid_r) begin
        flags_nxt.free_found = 1'b1;
        free_slot_nxt        = MY_IDX;
      end
    end
    if (wr_en && (wr_slot == MY_IDX)) begin
      valid_nxt = 1'b1;
      key_nxt   = wr_item.key;
      len_nxt   = wr_item.len;
      last_nxt  = wr_item.now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_vld_r <= tok_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    len_r       <= len_nxt;
    last_r      <= last_nxt;
    item_r      <= item_i;
    flags_r     <= flags_nxt;
    hit_slot_r  <= hit_slot_nxt;
    free_slot_r <= free_slot_nxt;
    evict_r     <= evict_nxt;
  end

  assign tok_vld_o   = tok_vld_r;
  assign item_o      = item_r;
  assign flags_o     = flags_r;
  assign hit_slot_o  = hit_slot_r;
  assign free_slot_o = free_slot_r;
  assign evict_o     = evict_r;
  assign valid_o     = valid_r;

endmodule
`default_nettype wire

@@ design/session_table_lookup_insert_age_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Session table with lookup, insert and timeout aging
// A row of cells, one per session entry. Each word travels down the row
// as a token; a final commit step claims a free slot for a new session and emits the result.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Contents
//  in_if     input      valid/ready    op, addr_key, addr_len, now_ticks
//  out_if    output     valid/ready    status, slot, live_count, evicted
//  cfg_*     input      write enable   timeout_ticks
//
//  A word walks the row as a token through one register per cell, then is
//  captured in the result registers and committed to the output register.
//  Reset is synchronous: all entries invalid, timeout back to 1000 ticks.
//  A stalled result holds in the output register; the next word is taken
//  meanwhile, but its commit waits until the output register is free.
// ----------------------------------------------------------------------------
module session_table_lookup_insert_age_core
  import stla_pkg::*;
#(
  parameter int MAX_SESSIONS = DEF_MAX_SESSIONS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  stla_in_if.sink                in_if,
  stla_out_if.source             out_if,
  input  wire logic              cfg_we,
  input  wire logic [TIME_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SESSIONS + 1);

  state_t state_r, state_nxt;

  logic [TIME_W-1:0] timeout_r;
  logic [CNT_W-1:0]  session_count_r, session_count_nxt;

  logic [MAX_SESSIONS:0] tok_vld;
  item_t                 item_s      [MAX_SESSIONS+1];
  flags_t                flags_s     [MAX_SESSIONS+1];
  logic [IDX_W-1:0]      hit_slot_s  [MAX_SESSIONS+1];
  logic [IDX_W-1:0]      free_slot_s [MAX_SESSIONS+1];
  logic [CNT_W-1:0]      evict_s     [MAX_SESSIONS+1];
  logic [MAX_SESSIONS-1:0] valid_vec;

  item_t            res_item_r;
  flags_t           res_flags_r;
  logic [IDX_W-1:0] res_hit_slot_r;
  logic [IDX_W-1:0] res_free_slot_r;
  logic [CNT_W-1:0] res_evict_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [COUNT_W-1:0]  out_live_r;
  logic [COUNT_W-1:0]  out_evicted_r, out_evicted_nxt;

  logic             in_fire;
  logic             out_free;
  logic             commit;
  logic             wr_en;
  logic [IDX_W-1:0] wr_slot;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (tok_vld[MAX_SESSIONS]) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = 1'b0;
    commit      = 1'b0;
    case (state_r)
      ST_IDLE: in_if.ready = 1'b1;
      ST_DONE: commit = out_free;
      default: begin
        in_if.ready = 1'b0;
        commit      = 1'b0;
      end
    endcase
  end

  assign tok_vld[0]     = in_fire;
  assign item_s[0]      = '{op: in_if.op, key: in_if.addr_key, len: in_if.addr_len,
                            now: in_if.now_ticks};
  assign flags_s[0]     = '0;
  assign hit_slot_s[0]  = '0;
  assign free_slot_s[0] = '0;
  assign evict_s[0]     = '0;

  for (genvar g = 0; g < MAX_SESSIONS; g++) begin : g_cell
    stla_cell #(
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W),
      .CELL_IDX     (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .timeout     (timeout_r),
      .tok_vld_i   (tok_vld[g]),
      .item_i      (item_s[g]),
      .flags_i     (flags_s[g]),
      .hit_slot_i  (hit_slot_s[g]),
      .free_slot_i (free_slot_s[g]),
      .evict_i     (evict_s[g]),
      .tok_vld_o   (tok_vld[g+1]),
      .item_o      (item_s[g+1]),
      .flags_o     (flags_s[g+1]),
      .hit_slot_o  (hit_slot_s[g+1]),
      .free_slot_o (free_slot_s[g+1]),
      .evict_o     (evict_s[g+1]),
      .wr_en       (wr_en),
      .wr_slot     (wr_slot),
      .wr_item     (res_item_r),
      .valid_o     (valid_vec[g])
    );
  end

  always_comb begin
    wr_en             = 1'b0;
    wr_slot           = res_free_slot_r;
    session_count_nxt = session_count_r;
    out_status_nxt    = STAT_FULL;
    out_slot_nxt      = '0;
    out_evicted_nxt   = '0;
    if (res_item_r.op == OP_AGE) begin
      out_status_nxt    = STAT_SWEEP;
      out_evicted_nxt   = COUNT_W'(res_evict_r);
      session_count_nxt = session_count_r - res_evict_r;
    end else if (res_flags_r.hit) begin
      out_status_nxt = STAT_HIT;
      out_slot_nxt   = SLOT_W'(res_hit_slot_r);
    end else if (res_flags_r.free_found) begin
      out_status_nxt    = STAT_NEW;
      out_slot_nxt      = SLOT_W'(res_free_slot_r);
      session_count_nxt = session_count_r + CNT_W'(1);
      wr_en             = commit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      timeout_r       <= TIMEOUT_RESET;
      session_count_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) timeout_r <= cfg_wdata;
      if (commit) begin
        session_count_r <= session_count_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_vld[MAX_SESSIONS]) begin
      res_item_r      <= item_s[MAX_SESSIONS];
      res_flags_r     <= flags_s[MAX_SESSIONS];
      res_hit_slot_r  <= hit_slot_s[MAX_SESSIONS];
      res_free_slot_r <= free_slot_s[MAX_SESSIONS];
      res_evict_r     <= evict_s[MAX_SESSIONS];
    end
    if (commit) begin
      out_status_r  <= out_status_nxt;
      out_slot_r    <= out_slot_nxt;
      out_live_r    <= COUNT_W'(session_count_nxt);
      out_evicted_r <= out_evicted_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.slot       = out_slot_r;
  assign out_if.live_count = out_live_r;
  assign out_if.evicted    = out_evicted_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one word in the cell row");

  a_token_exit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tok_vld[MAX_SESSIONS] |-> state_r == ST_RUN)
    else $error("token left the row outside the run state");

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> session_count_r == CNT_W'($countones(valid_vec)))
    else $error("session count differs from number of valid entries");

  a_write_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_valid_r && state_r == ST_IDLE)
    else $error("entry write without a result being issued");

endmodule
`default_nettype wire
